/* hw/rtl/skte_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted key table package
// Shared codes, enums and the command that the top level broadcasts to the
// row of table cells.
// ----------------------------------------------------------------------------
package skte_pkg;

   localparam int KeyWidth     = 16;
   localparam int PayloadWidth = 7;
   localparam int StatusWidth  = 3;
   localparam int OccWidth     = 5;

   // operation codes carried by an input item
   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_SEARCH = 2'd2,
      OP_POP    = 2'd3
   } opcode_type;

   // result status codes
   typedef enum logic [StatusWidth-1:0] {
      ST_OK       = 3'd0,
      ST_DUP      = 3'd1,
      ST_NOTFOUND = 3'd2,
      ST_EMPTY    = 3'd3,
      ST_FULL     = 3'd4
   } status_type;

   // what the row of cells does in the update cycle
   typedef enum logic [1:0] {
      ACT_NONE   = 2'd0,
      ACT_INSERT = 2'd1,
      ACT_REMOVE = 2'd2
   } action_type;

   // command broadcast to every cell
   typedef struct packed {
      logic                    cmp;      // latch compare flags this cycle
      logic                    first;    // select the smallest entry (pop)
      action_type              act;      // shift action this cycle
      logic [KeyWidth-1:0]     key;
      logic [PayloadWidth-1:0] payload;
   } cell_cmd_type;

endpackage

/* hw/rtl/skte_if.sv */
// ----------------------------------------------------------------------------
// Sorted key table channel interfaces
// Valid/ready channels for request items and response items.
// ----------------------------------------------------------------------------
interface skte_req_if;
   logic                              valid;
   logic                              ready;
   logic [1:0]                        opcode;
   logic [skte_pkg::KeyWidth-1:0]     key;
   logic [skte_pkg::PayloadWidth-1:0] payload;

   modport source (output valid, output opcode, output key, output payload,
                   input ready);
   modport sink   (input valid, input opcode, input key, input payload,
                   output ready);
endinterface

interface skte_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [skte_pkg::StatusWidth-1:0]  status;
   logic [skte_pkg::KeyWidth-1:0]     found_key;
   logic [skte_pkg::PayloadWidth-1:0] found_payload;
   logic [skte_pkg::OccWidth-1:0]     occupancy;

   modport source (output valid, output status, output found_key,
                   output found_payload, output occupancy, input ready);
   modport sink   (input valid, input status, input found_key,
                   input found_payload, input occupancy, output ready);
endinterface

/* hw/rtl/skte_cell.sv */
// ----------------------------------------------------------------------------
// Sorted key table cell
// Holds one table entry, compares it against the broadcast key and shifts
// entries to or from its neighbors on insert and remove.
// ----------------------------------------------------------------------------
module skte_cell #(
   parameter int IDX = 0,
   parameter int CW  = 5
) (
   input  logic                              clock,
   input  skte_pkg::cell_cmd_type            cmd,
   input  logic [CW-1:0]                     count,
   input  logic [skte_pkg::KeyWidth-1:0]     left_key,
   input  logic [skte_pkg::PayloadWidth-1:0] left_payload,
   input  logic                              left_lt,
   input  logic [skte_pkg::KeyWidth-1:0]     right_key,
   input  logic [skte_pkg::PayloadWidth-1:0] right_payload,
   output logic [skte_pkg::KeyWidth-1:0]     key,
   output logic [skte_pkg::PayloadWidth-1:0] payload,
   output logic                              lt,
   output logic                              sel,
   output logic [skte_pkg::KeyWidth-1:0]     sel_key,
   output logic [skte_pkg::PayloadWidth-1:0] sel_payload
);

   logic [skte_pkg::KeyWidth-1:0]     key_ff, key_in;
   logic [skte_pkg::PayloadWidth-1:0] payload_ff, payload_in;
   logic                              lt_ff, lt_in;
   logic                              eq_ff, eq_in;
   logic                              occ;

   // this slot holds a live entry
   assign occ = (count > CW'(IDX));

   // compare flags, latched in the compare cycle
   always_comb begin
      lt_in = lt_ff;
      eq_in = eq_ff;
      if (cmd.cmp) begin
         lt_in = occ && !cmd.first && (key_ff < cmd.key);
         eq_in = occ && (cmd.first || (key_ff == cmd.key));
      end
   end

   // entry update: entries below the split point stay put
   always_comb begin
      key_in     = key_ff;
      payload_in = payload_ff;
      case (cmd.act)
         skte_pkg::ACT_INSERT: begin
            if (!lt_ff) begin
               if (left_lt) begin
                  key_in     = cmd.key;
                  payload_in = cmd.payload;
               end else begin
                  key_in     = left_key;
                  payload_in = left_payload;
               end
            end
         end
         skte_pkg::ACT_REMOVE: begin
            if (!lt_ff) begin
               key_in     = right_key;
               payload_in = right_payload;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      payload_ff <= payload_in;
      lt_ff      <= lt_in;
      eq_ff      <= eq_in;
   end

   // the cell at the split point is the matching entry when eq is set
   assign sel         = !lt_ff && left_lt && eq_ff;
   assign sel_key     = sel ? key_ff : '0;
   assign sel_payload = sel ? payload_ff : '0;
   assign key         = key_ff;
   assign payload     = payload_ff;
   assign lt          = lt_ff;

endmodule

/* hw/rtl/sorted_key_table_engine_unit.sv */
// ----------------------------------------------------------------------------
// Sorted key table engine
// Keeps up to CAPACITY unique keys with payloads in ascending order in a row
// of cells; supports insert, delete, search and pop of the smallest key.
// ----------------------------------------------------------------------------
//  Channel   Dir  Type         Item content
//  req_ch    in   valid/ready  opcode, key, payload
//  rsp_ch    out  valid/ready  status, found_key, found_payload, occupancy
//
//  In the accept cycle every cell compares its key with the request key at
//  once; in the execute state, when the response register is free, the top
//  level resolves the hit; on a change the entries from the split point up shift.
//  Reset clears the entry count, the sequencer and the response register;
//  cell contents are undefined until written and are never read before.
//  A new item is accepted while a response waits; its update cycle holds
//  until the pending response has been taken.
// ----------------------------------------------------------------------------
module sorted_key_table_engine_unit #(
   parameter int CAPACITY = 16
) (
   input  logic        clock,
   input  logic        reset,
   skte_req_if.sink    req_ch,
   skte_rsp_if.source  rsp_ch
);

   localparam int CW = $clog2(CAPACITY + 1);

   typedef enum logic {
      S_IDLE = 1'b0,
      S_EXEC = 1'b1
   } state_type;

   state_type state_ff, state_in;

   logic [CW-1:0]                     count_ff, count_in;
   logic [1:0]                        op_ff, op_in;
   logic [skte_pkg::KeyWidth-1:0]     key_ff, key_in;
   logic [skte_pkg::PayloadWidth-1:0] pay_ff, pay_in;

   logic                                   rsp_valid_ff, rsp_valid_in;
   logic [skte_pkg::StatusWidth-1:0]       rsp_status_ff, rsp_status_in;
   logic [skte_pkg::KeyWidth-1:0]          rsp_key_ff, rsp_key_in;
   logic [skte_pkg::PayloadWidth-1:0]      rsp_pay_ff, rsp_pay_in;
   logic [skte_pkg::OccWidth-1:0]          rsp_occ_ff, rsp_occ_in;

   skte_pkg::cell_cmd_type cmd;

   logic [skte_pkg::KeyWidth-1:0]     cell_key   [CAPACITY];
   logic [skte_pkg::PayloadWidth-1:0] cell_pay   [CAPACITY];
   logic                              cell_lt    [CAPACITY];
   logic                              cell_sel   [CAPACITY];
   logic [skte_pkg::KeyWidth-1:0]     cell_skey  [CAPACITY];
   logic [skte_pkg::PayloadWidth-1:0] cell_spay  [CAPACITY];

   logic                              hit;
   logic [skte_pkg::KeyWidth-1:0]     hit_key;
   logic [skte_pkg::PayloadWidth-1:0] hit_pay;
   logic                              accept;
   logic                              out_free;
   logic                              full;
   logic                              empty;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign full         = (count_ff == CW'(CAPACITY));
   assign empty        = (count_ff == '0);

   // row of cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [skte_pkg::KeyWidth-1:0]     lkey, rkey;
      logic [skte_pkg::PayloadWidth-1:0] lpay, rpay;
      logic                              llt;

      if (i == 0) begin : g_first
         assign lkey = '0;
         assign lpay = '0;
         assign llt  = 1'b1;
      end else begin : g_mid
         assign lkey = cell_key[i-1];
         assign lpay = cell_pay[i-1];
         assign llt  = cell_lt[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign rkey = cell_key[i];
         assign rpay = cell_pay[i];
      end else begin : g_inner
         assign rkey = cell_key[i+1];
         assign rpay = cell_pay[i+1];
      end

      skte_cell #(
         .IDX (i),
         .CW  (CW)
      ) u_cell (
         .clock         (clock),
         .cmd           (cmd),
         .count         (count_ff),
         .left_key      (lkey),
         .left_payload  (lpay),
         .left_lt       (llt),
         .right_key     (rkey),
         .right_payload (rpay),
         .key           (cell_key[i]),
         .payload       (cell_pay[i]),
         .lt            (cell_lt[i]),
         .sel           (cell_sel[i]),
         .sel_key       (cell_skey[i]),
         .sel_payload   (cell_spay[i])
      );
   end

   // at most one cell flags a hit, so the selected fields OR together
   always_comb begin
      hit     = 1'b0;
      hit_key = '0;
      hit_pay = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         hit     = hit | cell_sel[i];
         hit_key = hit_key | cell_skey[i];
         hit_pay = hit_pay | cell_spay[i];
      end
   end

   // sequencer, cell command and response
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      pay_in        = pay_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_pay_in    = rsp_pay_ff;
      rsp_occ_in    = rsp_occ_ff;

      cmd.cmp     = 1'b0;
      cmd.first   = (req_ch.opcode == skte_pkg::OP_POP);
      cmd.act     = skte_pkg::ACT_NONE;
      cmd.key     = req_ch.key;
      cmd.payload = req_ch.payload;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.cmp  = 1'b1;
               op_in    = req_ch.opcode;
               key_in   = req_ch.key;
               pay_in   = req_ch.payload;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.key     = key_ff;
            cmd.payload = pay_ff;
            cmd.first   = (op_ff == skte_pkg::OP_POP);
            if (out_free) begin
               state_in      = S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = skte_pkg::ST_OK;
               rsp_key_in    = key_ff;
               rsp_pay_in    = '0;
               case (op_ff)
                  skte_pkg::OP_INSERT: begin
                     if (hit) begin
                        rsp_status_in = skte_pkg::ST_DUP;
                     end else if (full) begin
                        rsp_status_in = skte_pkg::ST_FULL;
                     end else begin
                        cmd.act  = skte_pkg::ACT_INSERT;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  skte_pkg::OP_DELETE, skte_pkg::OP_SEARCH: begin
                     if (empty) begin
                        rsp_status_in = skte_pkg::ST_EMPTY;
                     end else if (!hit) begin
                        rsp_status_in = skte_pkg::ST_NOTFOUND;
                     end else begin
                        rsp_pay_in = hit_pay;
                        if (op_ff == skte_pkg::OP_DELETE) begin
                           cmd.act  = skte_pkg::ACT_REMOVE;
                           count_in = count_ff - 1'b1;
                        end
                     end
                  end
                  default: begin
                     if (empty) begin
                        rsp_status_in = skte_pkg::ST_EMPTY;
                        rsp_key_in    = '0;
                     end else begin
                        rsp_key_in = hit_key;
                        rsp_pay_in = hit_pay;
                        cmd.act    = skte_pkg::ACT_REMOVE;
                        count_in   = count_ff - 1'b1;
                     end
                  end
               endcase
               rsp_occ_in = skte_pkg::OccWidth'(count_in);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // item and response payload
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      pay_ff        <= pay_in;
      rsp_status_ff <= rsp_status_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_pay_ff    <= rsp_pay_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.status        = rsp_status_ff;
   assign rsp_ch.found_key     = rsp_key_ff;
   assign rsp_ch.found_payload = rsp_pay_ff;
   assign rsp_ch.occupancy     = rsp_occ_ff;

endmodule
